// ===== rtl/core/sorted_unique_key_table_assert.svh =====
// Assertion macros for the sorted key table
`ifndef SORTED_UNIQUE_KEY_TABLE_ASSERT_SVH
`define SORTED_UNIQUE_KEY_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define SUKT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define SUKT_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define SUKT_ASSERT(label, prop)
`define SUKT_ASSERT_RST(label, prop)
`endif
`endif

// ===== rtl/core/sukt_pkg.sv =====
// Package: types, codes and sizes of the sorted key table
package sukt_pkg;
  localparam int Capacity = 16;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int KeyW = 34;
  localparam int RecW = 32;
  localparam int RankW = 4;
  localparam int OutCntW = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_DUP    = 3'd1,
    ST_FULL   = 3'd2,
    ST_ABSENT = 3'd3,
    ST_RANK   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FETCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [RecW-1:0] rec;
  } entry_t;
endpackage

// ===== rtl/core/sukt_ram.sv =====
// Entry memory: one write port, one registered read port
module sukt_ram
  import sukt_pkg::*;
(
  input  logic            clk,
  input  logic            we,
  input  logic [IdxW-1:0] waddr,
  input  entry_t          wdata,
  input  logic [IdxW-1:0] raddr,
  output entry_t          rdata
);
  entry_t mem [Capacity];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/sorted_unique_key_table.sv =====
// Top level: sorted key table over one entry memory, stream in and out
// Flow, accept to m_tvalid: read by rank goes FETCH then DONE; others go SCAN, SHIFT, DONE,
// where the scan reads entries up to the match (all of them when absent) and the shift moves
// entries only for an insert below the tail or a remove above the tail.
// One word at a time: the next word is accepted only after the result has been taken.
// Reset clears the count and control; memory contents are not cleared.
`include "sorted_unique_key_table_assert.svh"
module sorted_unique_key_table
  import sukt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // opcode[1:0], key[35:2], record[67:36], rank[71:68]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata   // status[2:0], found_key[36:3], found_record[68:37],
                                // entry_count[73:69], zero pad
);
  state_t state, state_next;
  logic [CntW-1:0] count;
  op_t op;
  logic [KeyW-1:0] key;
  logic [RecW-1:0] rec;
  logic [RankW-1:0] rank;
  logic [CntW-1:0] idx;     // address issued
  logic rvalid;             // rdata holds entry at idx-1
  logic [CntW-1:0] pos;     // insert position or match index
  logic hit;
  logic [CntW-1:0] sh;      // shift cursor
  status_t res_status;
  logic [KeyW-1:0] res_key;
  logic [RecW-1:0] res_rec;
  logic shift_last, shift_done;

  logic ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata, rdata;

  sukt_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rdata)
  );

  logic [CntW-1:0] ridx;
  assign ridx = idx - CntW'(1);
  logic scan_end;
  assign scan_end = rvalid && (ridx + CntW'(1) >= count);

  assign s_tready = (state == S_IDLE) && !m_tvalid;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid && s_tready) begin
        state_next = (op_t'(s_tdata[1:0]) == OP_READ) ? S_FETCH : S_SCAN;
      end
      S_SCAN:  if (count == '0 || hit || scan_end || (rvalid && rdata.key == key)) begin
        state_next = S_SHIFT;
      end
      S_SHIFT: if (shift_done) state_next = S_DONE;
      S_FETCH: state_next = rvalid ? S_DONE : S_FETCH;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // shift move: insert copies sh-1 -> sh going down; remove copies sh+1 -> sh going up
  logic ins_go, rem_go;
  assign ins_go = (op == OP_INSERT) && res_status == ST_OK && sh > pos;
  assign rem_go = (op == OP_REMOVE) && res_status == ST_OK && sh + CntW'(1) < count;
  assign shift_last = (op == OP_INSERT) && res_status == ST_OK && sh == pos;
  assign shift_done = shift_last || (!ram_we && !(ins_go || rem_go));

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = idx[IdxW-1:0];
    ram_wdata = rdata;
    ram_raddr = idx[IdxW-1:0];
    if (state == S_SHIFT) begin
      if (op == OP_INSERT) begin
        ram_raddr = rvalid ? IdxW'(sh - CntW'(2)) : IdxW'(sh - CntW'(1));
      end else begin
        ram_raddr = rvalid ? IdxW'(sh + CntW'(2)) : IdxW'(sh + CntW'(1));
      end
      if (res_status == ST_OK && (op == OP_INSERT || op == OP_REMOVE)) begin
        ram_waddr = sh[IdxW-1:0];
        if (op == OP_INSERT && sh == pos) begin
          ram_we = 1'b1;
          ram_wdata = '{key: key, rec: rec};
        end else if (rvalid && (ins_go || rem_go)) begin
          ram_we = 1'b1;
        end
      end
    end else if (state == S_FETCH) begin
      ram_raddr = rank[IdxW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      m_tvalid <= 1'b0;
      rvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          op <= op_t'(s_tdata[1:0]);
          key <= s_tdata[35:2];
          rec <= s_tdata[67:36];
          rank <= s_tdata[71:68];
          idx <= '0;
          rvalid <= 1'b0;
          pos <= '0;
          hit <= 1'b0;
          res_key <= '0;
          res_rec <= '0;
        end
        S_SCAN: begin
          if (!(hit || scan_end || (rvalid && rdata.key == key)) && count != '0) begin
            idx <= idx + CntW'(1);
            rvalid <= 1'b1;
            if (rvalid && rdata.key > key) pos <= ridx + CntW'(1);
          end
          if (count == '0 || scan_end || (rvalid && rdata.key == key) || hit) begin
            if (rvalid && rdata.key == key) begin
              pos <= ridx;
              res_key <= rdata.key;
              res_rec <= rdata.rec;
              hit <= 1'b1;
            end else if (rvalid && rdata.key > key) begin
              pos <= ridx + CntW'(1);
            end
            // select status and shift start
            if (op == OP_INSERT) begin
              if (rvalid && rdata.key == key) res_status <= ST_DUP;
              else if (count >= CntW'(Capacity)) res_status <= ST_FULL;
              else res_status <= ST_OK;
              sh <= count;
            end else begin
              res_status <= (rvalid && rdata.key == key) ? ST_OK : ST_ABSENT;
              sh <= ridx;
            end
            rvalid <= 1'b0;
          end
        end
        S_SHIFT: begin
          if (!rvalid && (ins_go || rem_go)) begin
            rvalid <= 1'b1;
          end else if (ram_we) begin
            if (op == OP_INSERT) sh <= sh - CntW'(1);
            else sh <= sh + CntW'(1);
          end
          if (shift_done) begin
            if (res_status == ST_OK && op == OP_INSERT) count <= count + CntW'(1);
            if (res_status == ST_OK && op == OP_REMOVE) count <= count - CntW'(1);
            if (op != OP_SEARCH) begin
              res_key <= '0;
              res_rec <= '0;
            end
          end
        end
        S_FETCH: begin
          rvalid <= 1'b1;
          if (rvalid) begin
            if ({1'b0, rank} >= (RankW+1)'(count)) begin
              res_status <= ST_RANK;
              res_key <= '0;
              res_rec <= '0;
            end else begin
              res_status <= ST_OK;
              res_key <= rdata.key;
              res_rec <= rdata.rec;
            end
          end
        end
        S_DONE: begin
          m_tvalid <= 1'b1;
          rvalid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {6'd0, OutCntW'(count), res_rec, res_key, res_status};

  `SUKT_ASSERT(a_count_le_cap, count <= CntW'(Capacity))
  `SUKT_ASSERT(a_no_accept_busy, (state != S_IDLE) |-> !s_tready)
  `SUKT_ASSERT(a_done_to_valid, (state == S_DONE) |=> m_tvalid)
  `SUKT_ASSERT_RST(a_rst_empty, rst |=> count == '0)
endmodule
